FILE: src/vad_pkg.sv
// ----------------------------------------------------------------------------
// Vertex attribute dedup package
// Field widths and slot counts shared by the channel interfaces and the core.
// ----------------------------------------------------------------------------
`default_nettype none

package vad_pkg;

    localparam int FIELD_W   = 16;
    localparam int OUT_IDX_W = 10;
    localparam int UV_SLOTS  = 4;
    localparam int MASK_W    = 4;

    localparam logic [MASK_W-1:0] MASK_RESET = 4'hF;

endpackage

`default_nettype wire

FILE: src/vad_if.sv
// ----------------------------------------------------------------------------
// Vertex attribute dedup channels
// Valid/ready interfaces for the corner key input and the vertex result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface vad_in_if
    import vad_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               new_mesh;
    logic [FIELD_W-1:0] pos_index;
    logic [FIELD_W-1:0] normal_index;
    logic [FIELD_W-1:0] uv_index_0;
    logic [FIELD_W-1:0] uv_index_1;
    logic [FIELD_W-1:0] uv_index_2;
    logic [FIELD_W-1:0] uv_index_3;

    modport source (
        output valid, new_mesh, pos_index, normal_index,
               uv_index_0, uv_index_1, uv_index_2, uv_index_3,
        input  ready
    );

    modport sink (
        input  valid, new_mesh, pos_index, normal_index,
               uv_index_0, uv_index_1, uv_index_2, uv_index_3,
        output ready
    );
endinterface

interface vad_out_if
    import vad_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [OUT_IDX_W-1:0] vertex_index;
    logic                 was_added;
    logic                 table_full;

    modport source (
        output valid, vertex_index, was_added, table_full,
        input  ready
    );

    modport sink (
        input  valid, vertex_index, was_added, table_full,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/vad_ram.sv
// ----------------------------------------------------------------------------
// Vertex attribute dedup RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module vad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: src/vertex_attribute_dedup_core.sv
// ----------------------------------------------------------------------------
// Vertex attribute dedup core
// Index buffer builder that maps face-corner keys to unique vertex numbers.
// ----------------------------------------------------------------------------
// Each accepted key is compared against the stored unique keys in insertion
// order, one stored entry per cycle through the read port of the key RAMs.
// A miss appends the key in the same pass; a new-mesh item empties the table
// at once by clearing the entry count, so the RAMs need no clearing pass after
// reset. The result waits in an output register, and the next key can be
// taken while it is still pending.
`default_nettype none

module vertex_attribute_dedup_core
    import vad_pkg::*;
#(
    parameter int MAX_VERTS   = 1024,
    parameter int INDEX_BITS  = 16,
    parameter int NUM_UV_MAPS = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [MASK_W-1:0] i_cfg_data,
    vad_in_if.sink                 i_in,
    vad_out_if.source              o_out
);

    localparam int ADDR_W = $clog2(MAX_VERTS);
    localparam int CNT_W  = $clog2(MAX_VERTS + 1);
    localparam int PN_W   = 2 * INDEX_BITS;
    localparam int UV_W   = NUM_UV_MAPS * INDEX_BITS;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [MASK_W-1:0]   r_uv_mask;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_issue, n_issue;
    logic                r_cmp_valid, n_cmp_valid;
    logic [ADDR_W-1:0]   r_cmp_addr, n_cmp_addr;
    logic                r_out_valid, n_out_valid;
    logic [PN_W-1:0]     r_key_pn;
    logic [UV_W-1:0]     r_key_uv;
    logic [ADDR_W-1:0]   r_res_idx, n_res_idx;
    logic                r_res_added, n_res_added;
    logic                r_res_full, n_res_full;
    logic [OUT_IDX_W-1:0] r_out_idx;
    logic                r_out_added;
    logic                r_out_full;

    logic [FIELD_W-1:0]  uv_in [UV_SLOTS];
    logic [PN_W-1:0]     in_pn;
    logic [UV_W-1:0]     in_uv;
    logic                in_xfer;
    logic                out_load;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [PN_W-1:0]     rd_pn;
    logic [UV_W-1:0]     rd_uv;
    logic                issue_more;
    logic                hit;
    logic [ADDR_W+OUT_IDX_W-1:0] res_ext;

    assign o_cfg_ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in.valid && (r_state == S_IDLE);

    assign uv_in[0] = i_in.uv_index_0;
    assign uv_in[1] = i_in.uv_index_1;
    assign uv_in[2] = i_in.uv_index_2;
    assign uv_in[3] = i_in.uv_index_3;

    assign in_pn = {i_in.pos_index[INDEX_BITS-1:0], i_in.normal_index[INDEX_BITS-1:0]};

    always_comb begin
        for (int k = 0; k < NUM_UV_MAPS; k++) begin
            in_uv[k*INDEX_BITS +: INDEX_BITS] =
                r_uv_mask[k] ? uv_in[k][INDEX_BITS-1:0] : {INDEX_BITS{1'b0}};
        end
    end

    vad_ram #(.WIDTH(PN_W), .DEPTH(MAX_VERTS)) u_pn_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_key_pn),
        .i_raddr (r_issue[ADDR_W-1:0]),
        .o_rdata (rd_pn)
    );

    vad_ram #(.WIDTH(UV_W), .DEPTH(MAX_VERTS)) u_uv_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_key_uv),
        .i_raddr (r_issue[ADDR_W-1:0]),
        .o_rdata (rd_uv)
    );

    assign issue_more = (r_issue < r_count);
    assign hit        = r_cmp_valid && (rd_pn == r_key_pn) && (rd_uv == r_key_uv);
    assign mem_waddr  = r_count[ADDR_W-1:0];
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_issue     = r_issue;
        n_cmp_valid = 1'b0;
        n_cmp_addr  = r_issue[ADDR_W-1:0];
        n_res_idx   = r_res_idx;
        n_res_added = r_res_added;
        n_res_full  = r_res_full;
        n_out_valid = r_out_valid && !o_out.ready;
        mem_we      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_issue = '0;
                    if (i_in.new_mesh) begin
                        n_count = '0;
                    end
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (issue_more) begin
                    n_issue     = r_issue + 1'b1;
                    n_cmp_valid = 1'b1;
                end
                if (hit) begin
                    n_cmp_valid = 1'b0;
                    n_res_idx   = r_cmp_addr;
                    n_res_added = 1'b0;
                    n_res_full  = 1'b0;
                    n_state     = S_DONE;
                end else if (!issue_more && !r_cmp_valid) begin
                    if (r_count == CNT_W'(MAX_VERTS)) begin
                        n_res_idx   = '0;
                        n_res_added = 1'b0;
                        n_res_full  = 1'b1;
                    end else begin
                        mem_we      = 1'b1;
                        n_count     = r_count + 1'b1;
                        n_res_idx   = r_count[ADDR_W-1:0];
                        n_res_added = 1'b1;
                        n_res_full  = 1'b0;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_uv_mask   <= MASK_RESET;
            r_count     <= '0;
            r_issue     <= '0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_issue     <= n_issue;
            r_cmp_valid <= n_cmp_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_uv_mask <= i_cfg_data;
            end
        end
    end

    assign res_ext = {{OUT_IDX_W{1'b0}}, r_res_idx};

    always_ff @(posedge i_clk) begin
        r_cmp_addr  <= n_cmp_addr;
        r_res_idx   <= n_res_idx;
        r_res_added <= n_res_added;
        r_res_full  <= n_res_full;
        if (in_xfer) begin
            r_key_pn <= in_pn;
            r_key_uv <= in_uv;
        end
        if (out_load) begin
            r_out_idx   <= res_ext[OUT_IDX_W-1:0];
            r_out_added <= r_res_added;
            r_out_full  <= r_res_full;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.vertex_index = r_out_idx;
    assign o_out.was_added    = r_out_added;
    assign o_out.table_full   = r_out_full;

endmodule

`default_nettype wire

FILE: tb/tb_vertex_attribute_dedup_core.sv
// ----------------------------------------------------------------------------
// Vertex attribute dedup core testbench
// Drives face-corner keys through the dedup core and checks every vertex
// result against a behavioral table model. Directed keys cover the field
// extremes, unused texture maps and a table holding two hundred keys. Random
// meshes built from small key pools follow, under several map masks and with
// idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_vertex_attribute_dedup_core;
    timeunit 1ns;
    timeprecision 1ps;

    import vad_pkg::*;

    localparam int MAX_VERTS    = 1024;
    localparam int INDEX_BITS   = 16;
    localparam int NUM_UV_MAPS  = 4;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = MAX_VERTS + 64;
    localparam int FILL_ITEMS   = 200;
    localparam int PHASE_ITEMS  = 36;
    localparam bit [FIELD_W-1:0] IDX_MASK = FIELD_W'((1 << INDEX_BITS) - 1);

    typedef struct packed {
        bit                             new_mesh;
        bit [FIELD_W-1:0]               pos_index;
        bit [FIELD_W-1:0]               normal_index;
        bit [UV_SLOTS-1:0][FIELD_W-1:0] uv_index;
    } corner_key_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] vertex_index;
        logic                 was_added;
        logic                 table_full;
    } vertex_result_t;

    class vertex_table_model;
        bit [2*FIELD_W-1:0]        pos_normal_ram [MAX_VERTS];
        bit [UV_SLOTS*FIELD_W-1:0] uv_ram [MAX_VERTS];
        int unsigned               used_entries;
        bit [MASK_W-1:0]           map_mask;
        vertex_result_t            expected_vertices [$];
        int unsigned               mismatch_count;

        function new();
            used_entries   = 0;
            map_mask       = MASK_RESET;
            mismatch_count = 0;
        endfunction

        function void set_mask(bit [MASK_W-1:0] value);
            map_mask = value;
        endfunction

        function void note_key(corner_key_t key);
            bit [2*FIELD_W-1:0]        pn;
            bit [UV_SLOTS*FIELD_W-1:0] uv;
            vertex_result_t            res;
            bit                        found;
            int                        m;
            int unsigned               i;
            if (key.new_mesh) begin
                used_entries = 0;
            end
            pn = {key.pos_index & IDX_MASK, key.normal_index & IDX_MASK};
            uv = '0;
            for (m = 0; m < UV_SLOTS; m++) begin
                if (m < NUM_UV_MAPS && map_mask[m]) begin
                    uv[FIELD_W*m +: FIELD_W] = key.uv_index[m] & IDX_MASK;
                end
            end
            found = 1'b0;
            res   = '0;
            for (i = 0; i < used_entries && !found; i++) begin
                if (pos_normal_ram[i] == pn && uv_ram[i] == uv) begin
                    res.vertex_index = i[OUT_IDX_W-1:0];
                    found = 1'b1;
                end
            end
            if (!found) begin
                if (used_entries >= MAX_VERTS) begin
                    res.table_full = 1'b1;
                end else begin
                    pos_normal_ram[used_entries] = pn;
                    uv_ram[used_entries]         = uv;
                    res.vertex_index             = used_entries[OUT_IDX_W-1:0];
                    res.was_added                = 1'b1;
                    used_entries++;
                end
            end
            expected_vertices.push_back(res);
        endfunction

        task report_mismatch(string what);
            mismatch_count++;
            if (mismatch_count <= 50) begin
                $display("ERROR at %0t: %s", $time, what);
            end
        endtask

        task check_vertex(vertex_result_t got);
            vertex_result_t want;
            if (expected_vertices.size() == 0) begin
                report_mismatch($sformatf("unexpected result, vertex_index %0d",
                                          got.vertex_index));
                return;
            end
            want = expected_vertices.pop_front();
            if (got.vertex_index !== want.vertex_index) begin
                report_mismatch($sformatf("vertex_index %0d, wanted %0d",
                                          got.vertex_index, want.vertex_index));
            end
            if (got.was_added !== want.was_added) begin
                report_mismatch($sformatf("was_added %b, wanted %b",
                                          got.was_added, want.was_added));
            end
            if (got.table_full !== want.table_full) begin
                report_mismatch($sformatf("table_full %b, wanted %b",
                                          got.table_full, want.table_full));
            end
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [MASK_W-1:0] i_cfg_data;

    vad_in_if  key_ch ();
    vad_out_if result_ch ();

    vertex_table_model sb = new();

    int idle_pct    = 0;
    int stall_pct   = 0;
    int quiet_cycles = 0;

    vertex_attribute_dedup_core #(
        .MAX_VERTS   (MAX_VERTS),
        .INDEX_BITS  (INDEX_BITS),
        .NUM_UV_MAPS (NUM_UV_MAPS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in        (key_ch),
        .o_out       (result_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            sb.check_vertex(vertex_result_t'{result_ch.vertex_index,
                                             result_ch.was_added,
                                             result_ch.table_full});
        end
        result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if ((key_ch.valid && key_ch.ready) || (result_ch.valid && result_ch.ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic corner_key_t make_key(bit nm, bit [FIELD_W-1:0] pos,
                                             bit [FIELD_W-1:0] nrm, bit [FIELD_W-1:0] u0,
                                             bit [FIELD_W-1:0] u1, bit [FIELD_W-1:0] u2,
                                             bit [FIELD_W-1:0] u3);
        corner_key_t k;
        k.new_mesh     = nm;
        k.pos_index    = pos;
        k.normal_index = nrm;
        k.uv_index[0]  = u0;
        k.uv_index[1]  = u1;
        k.uv_index[2]  = u2;
        k.uv_index[3]  = u3;
        return k;
    endfunction

    function automatic corner_key_t random_key(bit nm);
        return make_key(nm, FIELD_W'($urandom()), FIELD_W'($urandom()),
                        FIELD_W'($urandom()), FIELD_W'($urandom()),
                        FIELD_W'($urandom()), FIELD_W'($urandom()));
    endfunction

    // Unused maps must not affect the lookup, so their indices get new noise.
    function automatic corner_key_t scramble_unused(corner_key_t k);
        int m;
        for (m = 0; m < UV_SLOTS; m++) begin
            if (!sb.map_mask[m]) begin
                k.uv_index[m] = FIELD_W'($urandom());
            end
        end
        return k;
    endfunction

    task automatic send_key(corner_key_t k);
        while ($urandom_range(0, 99) < idle_pct) begin
            key_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        key_ch.valid        <= 1'b1;
        key_ch.new_mesh     <= k.new_mesh;
        key_ch.pos_index    <= k.pos_index;
        key_ch.normal_index <= k.normal_index;
        key_ch.uv_index_0   <= k.uv_index[0];
        key_ch.uv_index_1   <= k.uv_index[1];
        key_ch.uv_index_2   <= k.uv_index[2];
        key_ch.uv_index_3   <= k.uv_index[3];
        @(posedge i_clk);
        while (!key_ch.ready) begin
            @(posedge i_clk);
        end
        sb.note_key(k);
    endtask

    task automatic wait_drained();
        key_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_vertices.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_mask(bit [MASK_W-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        sb.set_mask(value);
    endtask

    initial begin
        corner_key_t k;
        corner_key_t fill_keys [$];
        corner_key_t key_pool [$];
        int n;
        int phase;
        int items_left;
        int mesh_len;
        int pool_target;
        int j;
        int r;
        bit start_new;

        i_rst_n             = 1'b0;
        i_cfg_valid         = 1'b0;
        i_cfg_data          = '0;
        key_ch.valid        = 1'b0;
        key_ch.new_mesh     = 1'b0;
        key_ch.pos_index    = '0;
        key_ch.normal_index = '0;
        key_ch.uv_index_0   = '0;
        key_ch.uv_index_1   = '0;
        key_ch.uv_index_2   = '0;
        key_ch.uv_index_3   = '0;
        result_ch.ready     = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed keys under the reset mask, with every map in use.
        send_key(make_key(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_key(make_key(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_key(make_key(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_key(make_key(1'b0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_key(make_key(1'b0, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_key(make_key(1'b0, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
        send_key(make_key(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000));
        send_key(make_key(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000));
        send_key(make_key(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
        send_key(make_key(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_key(make_key(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_key(make_key(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));

        // With no maps in use only the position and normal count.
        write_mask('0);
        send_key(make_key(1'b1, 16'h1234, 16'h5678, 16'hAAAA, 16'h5555, 16'h0F0F, 16'hF0F0));
        send_key(make_key(1'b0, 16'h1234, 16'h5678, 16'h5555, 16'hAAAA, 16'hF0F0, 16'h0F0F));

        write_mask(4'b0101);
        send_key(make_key(1'b1, 16'h4321, 16'h8765, 16'h1111, 16'h2222, 16'h3333, 16'h4444));
        send_key(make_key(1'b0, 16'h4321, 16'h8765, 16'h1111, 16'hDDDD, 16'h3333, 16'hBBBB));
        send_key(make_key(1'b0, 16'h4321, 16'h8765, 16'hEEEE, 16'h2222, 16'h3333, 16'h4444));
        send_key(make_key(1'b0, 16'h4321, 16'h8765, 16'h1111, 16'h2222, 16'hCCCC, 16'h4444));

        // Fill two hundred entries of the table, then look up keys at both ends and add more.
        write_mask(MASK_RESET);
        for (n = 0; n < FILL_ITEMS; n++) begin
            k = random_key(n == 0);
            k.pos_index = n[FIELD_W-1:0];
            send_key(k);
            k.new_mesh = 1'b0;
            fill_keys.push_back(k);
        end
        send_key(fill_keys[FILL_ITEMS-1]);
        send_key(fill_keys[0]);
        for (n = 0; n < 3; n++) begin
            k = random_key(1'b0);
            k.pos_index = FIELD_W'($urandom_range(FILL_ITEMS, 65535));
            send_key(k);
        end
        send_key(k);
        send_key(fill_keys[$urandom_range(0, FILL_ITEMS - 1)]);
        send_key(random_key(1'b1));
        send_key(fill_keys[5]);

        // Random meshes drawn from small key pools.
        for (phase = 0; phase < 10; phase++) begin
            case (phase)
                0: write_mask(4'b1111);
                1: write_mask(4'b0000);
                2: write_mask(4'b0001);
                3: write_mask(4'b1000);
                default: write_mask(MASK_W'($urandom_range(0, 15)));
            endcase
            case (phase % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 45;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 45;
                end
                default: begin
                    idle_pct  = 31;
                    stall_pct = 31;
                end
            endcase
            items_left = PHASE_ITEMS;
            while (items_left > 0) begin
                mesh_len    = $urandom_range(1, 40);
                if (mesh_len > items_left) begin
                    mesh_len = items_left;
                end
                items_left -= mesh_len;
                pool_target = $urandom_range(1, 12);
                start_new   = ($urandom_range(0, 4) != 0);
                key_pool.delete();
                for (j = 0; j < mesh_len; j++) begin
                    r = $urandom_range(0, 99);
                    if (key_pool.size() == 0 || r < 12
                            || (key_pool.size() < pool_target && r < 40)) begin
                        k = random_key(1'b0);
                        key_pool.push_back(k);
                    end else begin
                        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
                        if ($urandom_range(0, 1)) begin
                            k = scramble_unused(k);
                        end
                    end
                    k.new_mesh = (j == 0 && start_new) || ($urandom_range(0, 99) < 3);
                    send_key(k);
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.expected_vertices.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
